// File: src/cmpatan_pkg.sv
`default_nettype none
package cmpatan_pkg;

    // vector components: 16 integer bits scaled by 2^16, plus cordic gain and sign
    localparam int CORDIC_XW  = 36;
    localparam int ANGLE_W    = 32;
    localparam int PROD_W     = 48;
    localparam int HEADING_W  = 16;
    localparam int ATAN_ENTRIES = 24;

    typedef logic signed [CORDIC_XW-1:0] t_vec;
    typedef logic [ANGLE_W-1:0]          t_angle;
    typedef logic [HEADING_W-1:0]        t_heading;
    typedef logic [PROD_W-1:0]           t_prod;

    localparam t_angle   HALF_TURN         = 32'h8000_0000;
    localparam t_heading CENTIDEG_PER_TURN = 16'd36000;

    // atan(2^-idx) as a binary angle, full turn = 2^32
    function automatic t_angle atan_turn(input logic [4:0] idx);
        t_angle v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2F9;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/cmpatan_if.sv
`default_nettype none
interface cmpatan_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  x_field;
    logic signed [15:0]  y_field;

    modport source (output valid, output x_field, output y_field, input ready);
    modport sink   (input valid, input x_field, input y_field, output ready);
endinterface

interface cmpatan_out_if;
    logic         valid;
    logic         ready;
    logic [15:0]  heading_centideg;

    modport source (output valid, output heading_centideg, input ready);
    modport sink   (input valid, input heading_centideg, output ready);
endinterface
`default_nettype wire

// File: src/cmpatan_iter.sv
`default_nettype none
module cmpatan_iter import cmpatan_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_vec   i_x,
    input  wire t_vec   i_y,
    input  wire t_angle i_ang,
    output t_vec      o_x,
    output t_vec      o_y,
    output t_angle    o_ang
);

    localparam t_angle ATAN_STEP = atan_turn(5'(SHIFT));

    t_vec   w_dx;
    t_vec   w_dy;
    t_vec   n_x;
    t_vec   n_y;
    t_angle n_ang;
    t_vec   r_x;
    t_vec   r_y;
    t_angle r_ang;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;

    // rotate toward the x axis, direction from the sign of y
    always_comb begin
        if (!i_y[CORDIC_XW-1]) begin
            n_x   = i_x + w_dx;
            n_y   = i_y - w_dy;
            n_ang = i_ang + ATAN_STEP;
        end else begin
            n_x   = i_x - w_dx;
            n_y   = i_y + w_dy;
            n_ang = i_ang - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ang <= n_ang;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_ang = r_ang;

endmodule
`default_nettype wire

// File: src/compass_heading_atan2.sv
// compass heading from one magnetometer sample pair, by a pipelined cordic
//
// request in (i_in): signed 16-bit x_field and y_field, taken when valid and
// ready are both high. result out (o_out): heading_centideg, atan2(y, x) in
// hundredths of a degree folded into 0..35999, rounded to nearest
// x and y both zero give a heading of 0
//
// pipeline: one register for the half-plane fold, one register per cordic
// iteration (CORDIC_STEPS of them, at most 24), one for the 32x16 scale to
// centidegrees, and the output register, which takes the rounded heading.
// throughput is one request per clock while o_out.ready stays high: every stage holds a full item
// ready ripples back from the output: a stage loads whenever it is empty or
// the stage after it moves, so bubbles collapse and a stalled receiver holds
// the output while upstream stages keep filling until the whole pipe is full
// nothing is dropped or repeated under backpressure
// reset (synchronous, active low) clears all valid bits; payload is unreset
`default_nettype none
module compass_heading_atan2 import cmpatan_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    cmpatan_in_if.sink     i_in,
    cmpatan_out_if.source  o_out
);

    // stage map: 0 fold, 1..NS cordic, NS+1 multiply, NS+2 output
    localparam int NS   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int LAST = NS + 2;

    logic   r_v    [0:LAST];
    logic   w_rdy  [0:LAST+1];
    logic   r_zero [0:NS+1];

    // fold stage
    t_vec   n_x0;
    t_vec   n_y0;
    t_angle n_ang0;
    t_vec   r_x0;
    t_vec   r_y0;
    t_angle r_ang0;

    // cordic stage outputs
    t_vec   w_x   [1:NS];
    t_vec   w_y   [1:NS];
    t_angle w_ang [1:NS];

    // scale and round
    t_prod    r_prod;
    t_prod    n_sum;
    t_heading n_round;
    t_heading n_heading;
    t_heading r_heading;

    // ready chain, from the output back to the input
    always_comb begin
        w_rdy[LAST+1] = o_out.ready;
        for (int k = LAST; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign i_in.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // zero vector flag rides along to the rounding stage
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_zero[0] <= (i_in.x_field == '0) && (i_in.y_field == '0);
        end
        for (int k = 1; k <= NS + 1; k++) begin
            if (w_rdy[k]) begin
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    // left half plane: turn by half a turn, start the angle there
    always_comb begin
        if (i_in.x_field[15]) begin
            n_x0   = -(CORDIC_XW'(i_in.x_field) <<< 16);
            n_y0   = -(CORDIC_XW'(i_in.y_field) <<< 16);
            n_ang0 = HALF_TURN;
        end else begin
            n_x0   = CORDIC_XW'(i_in.x_field) <<< 16;
            n_y0   = CORDIC_XW'(i_in.y_field) <<< 16;
            n_ang0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_x0   <= n_x0;
            r_y0   <= n_y0;
            r_ang0 <= n_ang0;
        end
    end

    // one vectoring iteration per stage
    for (genvar g = 0; g < NS; g++) begin : g_iter
        if (g == 0) begin : g_first
            cmpatan_iter #(.SHIFT(g)) u_iter (
                .i_clk (i_clk),
                .i_en  (w_rdy[g+1]),
                .i_x   (r_x0),
                .i_y   (r_y0),
                .i_ang (r_ang0),
                .o_x   (w_x[g+1]),
                .o_y   (w_y[g+1]),
                .o_ang (w_ang[g+1])
            );
        end else begin : g_next
            cmpatan_iter #(.SHIFT(g)) u_iter (
                .i_clk (i_clk),
                .i_en  (w_rdy[g+1]),
                .i_x   (w_x[g]),
                .i_y   (w_y[g]),
                .i_ang (w_ang[g]),
                .o_x   (w_x[g+1]),
                .o_y   (w_y[g+1]),
                .o_ang (w_ang[g+1])
            );
        end
    end

    // binary angle to centidegrees: angle * 36000 / 2^32
    always_ff @(posedge i_clk) begin
        if (w_rdy[NS+1]) begin
            r_prod <= PROD_W'(w_ang[NS]) * PROD_W'(CENTIDEG_PER_TURN);
        end
    end

    // round half up, wrap a full turn to zero
    always_comb begin
        n_sum     = r_prod + PROD_W'(HALF_TURN);
        n_round   = n_sum[PROD_W-1:ANGLE_W];
        n_heading = (r_zero[NS+1] || (n_round >= CENTIDEG_PER_TURN)) ? '0 : n_round;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[LAST]) begin
            r_heading <= n_heading;
        end
    end

    assign o_out.valid            = r_v[LAST];
    assign o_out.heading_centideg = r_heading;

    // x and y components of the last stage are not needed past the final iteration
    logic w_unused_y;
    assign w_unused_y = ^w_y[NS] ^ ^w_x[NS];

endmodule
`default_nettype wire

// File: bench/compass_heading_atan2_tb.sv
`default_nettype none
module compass_heading_atan2_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmpatan_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int STEPS        = 16;
    localparam int LATENCY      = STEPS + 2;
    localparam int TAIL_CYCLES  = 2 * LATENCY + 8;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the pipe
    localparam int STALL_LIMIT  = 4000;    // cycles with no request and no result moving
    localparam int MAX_REPORTS  = 10;

    // atan(2^-k) in binary angle units, a full turn being 2^32
    localparam t_angle ATAN_STEP [ATAN_ENTRIES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    // one directed request; want is only meaningful when typed is set
    typedef struct {
        int x;
        int y;
        bit typed;
        int want;
    } pair_row_t;

    localparam int N_DIR = 22;

    pair_row_t dir_rows [N_DIR] = '{
        '{0, 0, 1'b1, 0},              // zero vector gives heading 0
        '{32767, 0, 1'b0, 0},          // full scale on each axis
        '{-32768, 0, 1'b0, 0},
        '{0, 32767, 1'b0, 0},
        '{0, -32768, 1'b0, 0},
        '{32767, 32767, 1'b0, 0},      // full scale diagonals
        '{-32768, -32768, 1'b0, 0},
        '{-32768, 32767, 1'b0, 0},
        '{32767, -32768, 1'b0, 0},
        '{1, 0, 1'b0, 0},              // unit vectors
        '{-1, 0, 1'b0, 0},
        '{0, 1, 1'b0, 0},
        '{0, -1, 1'b0, 0},
        '{1, 1, 1'b0, 0},
        '{-1, 1, 1'b0, 0},
        '{-1, -1, 1'b0, 0},
        '{1, -1, 1'b0, 0},
        '{32767, -1, 1'b0, 0},         // just below a full turn, rounds up and wraps
        '{32767, -2, 1'b0, 0},
        '{-32768, 1, 1'b0, 0},         // left half plane close to 180 degrees
        '{-32768, -1, 1'b0, 0},
        '{0, 0, 1'b1, 0}               // zero vector again after nonzero traffic
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cmpatan_in_if  in_if ();
    cmpatan_out_if out_if ();

    compass_heading_atan2 #(
        .CORDIC_STEPS (STEPS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_heading expected_headings [$];
    int       err_cnt = 0;
    int       stuck_cycles = 0;
    bit       tx_idle;
    bit       rx_idle;
    bit       hold_req;

    // vectoring cordic, same fixed-point scaling as the block: 16 fraction bits,
    // floor shifts, 32-bit wrapping angle, then rounding to centidegrees
    function automatic t_heading heading_of(input logic signed [15:0] xf,
                                            input logic signed [15:0] yf);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        t_angle      ang;
        logic [63:0] scaled;
        if (xf == 0 && yf == 0)
            return '0;
        vx  = xf;
        vy  = yf;
        ang = '0;
        // left half plane: turn the vector by half a turn first
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = HALF_TURN;
        end
        vx = vx * 65536;
        vy = vy * 65536;
        for (int k = 0; k < STEPS && k < ATAN_ENTRIES; k++) begin
            sx = vy >>> k;
            sy = vx >>> k;
            if (vy >= 0) begin
                vx  = vx + sx;
                vy  = vy - sy;
                ang = ang + ATAN_STEP[k];
            end else begin
                vx  = vx - sx;
                vy  = vy + sy;
                ang = ang - ATAN_STEP[k];
            end
        end
        scaled = (64'(ang) * 64'(CENTIDEG_PER_TURN) + 64'h8000_0000) >> 32;
        // a rounded full turn folds back to zero
        if (scaled >= 64'(CENTIDEG_PER_TURN))
            return '0;
        return t_heading'(scaled);
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int span(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic int pick_edge();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic flag_error(input string what, input t_heading want, input t_heading got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic push_pair(input logic signed [15:0] xv, input logic signed [15:0] yv,
                             input bit typed, input t_heading want);
        int gap;
        in_if.valid   <= 1'b1;
        in_if.x_field <= xv;
        in_if.y_field <= yv;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        expected_headings.push_back(typed ? want : heading_of(xv, yv));
        @(negedge i_clk);
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            // payload goes to junk while valid is low
            in_if.valid   <= 1'b0;
            in_if.x_field <= 16'($urandom);
            in_if.y_field <= 16'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random();
        int xv;
        int yv;
        int v;
        case ($urandom_range(0, 9))
            5: begin
                xv = span(8);
                yv = span(8);
            end
            6: begin
                // axes and diagonals
                v = int'($urandom_range(0, 65535)) - 32768;
                case ($urandom_range(0, 3))
                    0:       begin xv = v;  yv = 0;  end
                    1:       begin xv = 0;  yv = v;  end
                    2:       begin xv = v;  yv = v;  end
                    default: begin xv = v;  yv = -v; end
                endcase
            end
            7: begin
                xv = pick_edge();
                yv = pick_edge();
            end
            8: begin
                // near the x axis: wrap at a full turn, or close to 180 degrees
                xv = $urandom_range(1000, 32767);
                yv = span(3);
                if ($urandom_range(0, 1))
                    xv = -xv;
            end
            9: begin
                xv = span(300);
                yv = span(300);
            end
            default: begin
                xv = int'($urandom_range(0, 65535)) - 32768;
                yv = int'($urandom_range(0, 65535)) - 32768;
            end
        endcase
        push_pair(16'(xv), 16'(yv), 1'b0, '0);
    endtask

    // sender stops until every outstanding heading has come back
    task automatic drain_pause();
        in_if.valid <= 1'b0;
        while (expected_headings.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        in_if.valid   = 1'b0;
        in_if.x_field = '0;
        in_if.y_field = '0;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        hold_req      = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r])
            push_pair(16'(dir_rows[r].x), 16'(dir_rows[r].y), dir_rows[r].typed,
                      t_heading'(dir_rows[r].want));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // phases: no idling, both idling, receiver hold-off with a
            // steady sender, drain and both idling, then each side idling alone
            if (n == 0) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            if (n == 400) begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            if (n == 900) begin
                tx_idle  = 1'b0;
                hold_req = 1'b1;
            end
            if (n == 1000) begin
                drain_pause();
                tx_idle = 1'b1;
            end
            if (n == 1400)
                rx_idle = 1'b0;
            if (n == 1700) begin
                rx_idle = 1'b1;
                tx_idle = 1'b0;
            end
            send_random();
        end

        in_if.valid <= 1'b0;
        while (expected_headings.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && expected_headings.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, and one long hold-off when asked
    initial begin : receiver
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
                if (rx_idle)
                    stall = pick_gap();
            end
        end
    end

    // every heading taken is matched against the oldest pending one
    always @(posedge i_clk) begin : result_check
        t_heading want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_headings.size() == 0) begin
                flag_error("heading with no request pending", 'x, out_if.heading_centideg);
            end else begin
                want = expected_headings.pop_front();
                if (out_if.heading_centideg !== want)
                    flag_error("heading mismatch", want, out_if.heading_centideg);
            end
        end
    end

    // watchdog: nothing moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
`default_nettype wire
